>>> src/idc_pkg.sv
// Package for the ISA DMA channel controller: word layouts, port codes and the
// page register port decoder. No dependencies.
`default_nettype none

package idc_pkg;

    // item modes
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_ACK   = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    // control ports (low byte, high byte of the port number is zero)
    localparam logic [7:0] PORT_STATUS_SLV = 8'h08;
    localparam logic [7:0] PORT_MASK_SLV   = 8'h0A;
    localparam logic [7:0] PORT_MODE_SLV   = 8'h0B;
    localparam logic [7:0] PORT_CLRFF_SLV  = 8'h0C;
    localparam logic [7:0] PORT_MCLR_SLV   = 8'h0D;
    localparam logic [7:0] PORT_STATUS_MST = 8'hD0;
    localparam logic [7:0] PORT_MASK_MST   = 8'hD4;
    localparam logic [7:0] PORT_MODE_MST   = 8'hD6;
    localparam logic [7:0] PORT_CLRFF_MST  = 8'hD8;
    localparam logic [7:0] PORT_MCLR_MST   = 8'hDA;

    // channel mode register bits
    localparam int MODE_BIT_AUTOINIT  = 4;
    localparam int MODE_BIT_DECREMENT = 5;

    typedef struct packed {
        logic       hit;
        logic [2:0] chan;
    } page_hit_t;

    function automatic page_hit_t page_lookup(input logic [15:0] port);
        page_hit_t r;
        r.hit  = 1'b1;
        r.chan = 3'd0;
        unique case (port)
            16'h0087: r.chan = 3'd0;
            16'h0083: r.chan = 3'd1;
            16'h0081: r.chan = 3'd2;
            16'h0082: r.chan = 3'd3;
            16'h008F: r.chan = 3'd4;
            16'h008B: r.chan = 3'd5;
            16'h0089: r.chan = 3'd6;
            16'h008A: r.chan = 3'd7;
            default:  r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/idc_req_if.sv
// Request channel of the ISA DMA channel controller: valid/ready plus one item.
// No dependencies.
`default_nettype none

interface idc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] bus_port;
    logic [7:0]  write_data;
    logic [2:0]  channel;
    logic [15:0] byte_count;

    modport source (output valid, mode, bus_port, write_data, channel, byte_count,
                    input ready);
    modport sink   (input valid, mode, bus_port, write_data, channel, byte_count,
                    output ready);
endinterface

`default_nettype wire

>>> src/idc_rsp_if.sv
// Response channel of the ISA DMA channel controller: valid/ready plus one result.
// No dependencies.
`default_nettype none

interface idc_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        terminal_count;
    logic [23:0] linear_address;
    logic [15:0] current_count;

    modport source (output valid, read_data, terminal_count, linear_address,
                    current_count, input ready);
    modport sink   (input valid, read_data, terminal_count, linear_address,
                    current_count, output ready);
endinterface

`default_nettype wire

>>> src/isa_dma_channel_controller_core.sv
// Pair of cascaded four-channel DMA controllers with page registers: bus register
// model. Depends on idc_pkg, idc_req_if and idc_rsp_if.
`default_nettype none

// One word is taken per clock when the result register can move on; each word is
// held in the request register, then decoded and applied to the register file,
// and its result is loaded into the result register. The register file update
// (one indexed read per array, one add/subtract and compare) sets the cycle. Slave
// ports cover channels 0-3, master ports channels 4-7; status reads leave the
// terminal count bits set.
module isa_dma_channel_controller_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    idc_req_if.sink    req,
    idc_rsp_if.source  rsp
);
    import idc_pkg::*;

    // request register
    logic        s1_valid_reg;
    logic [1:0]  s1_mode_reg;
    logic [15:0] s1_port_reg;
    logic [7:0]  s1_wdata_reg;
    logic [2:0]  s1_chan_reg;
    logic [15:0] s1_bytes_reg;

    // register file
    logic [15:0] base_addr_reg [8];
    logic [15:0] base_cnt_reg  [8];
    logic [15:0] cur_addr_reg  [8];
    logic [15:0] cur_cnt_reg   [8];
    logic [7:0]  page_reg      [8];
    logic [7:0]  chan_mode_reg [8];
    logic [7:0]  masked_reg;
    logic [1:0]  byte_ff_reg;
    logic [7:0]  tc_status_reg;   // [3:0] slave, [7:4] master

    logic [15:0] base_addr_next [8];
    logic [15:0] base_cnt_next  [8];
    logic [15:0] cur_addr_next  [8];
    logic [15:0] cur_cnt_next   [8];
    logic [7:0]  page_next      [8];
    logic [7:0]  chan_mode_next [8];
    logic [7:0]  masked_next;
    logic [1:0]  byte_ff_next;
    logic [7:0]  tc_status_next;

    // result register
    logic        rsp_valid_reg;
    logic [7:0]  rsp_rdata_reg;
    logic        rsp_tc_reg;
    logic [23:0] rsp_linear_reg;
    logic [15:0] rsp_count_reg;
    logic        rsp_valid_next;
    logic [7:0]  rsp_rdata_next;
    logic        rsp_tc_next;
    logic [23:0] rsp_linear_next;
    logic [15:0] rsp_count_next;

    logic advance;
    logic fire;

    // decode
    logic        ac_slave;
    logic        ac_master;
    logic        ac_hit;
    logic        ac_is_count;
    logic [2:0]  ac_chan;
    logic        low_page;
    logic [7:0]  port_lo;
    page_hit_t   pg;
    logic [2:0]  idx_cur;
    logic [2:0]  idx_page;

    // indexed reads
    logic [15:0] base_addr_rd;
    logic [15:0] base_cnt_rd;
    logic [15:0] cur_addr_rd;
    logic [15:0] cur_cnt_rd;
    logic [7:0]  page_rd;
    logic [7:0]  chan_mode_rd;
    logic [15:0] ac_val;
    logic [15:0] ac_new_base;

    // acknowledge
    logic [15:0] units_raw;
    logic [15:0] units;
    logic [15:0] addr_step;
    logic [16:0] cnt_diff;
    logic        ack_tc;
    logic [23:0] query_off;

    assign advance   = !rsp_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;

    assign ac_slave    = (s1_port_reg[15:3] == 13'd0);
    assign ac_master   = (s1_port_reg[15:4] == 12'h00C) && !s1_port_reg[0];
    assign ac_hit      = ac_slave || ac_master;
    assign ac_is_count = ac_master ? s1_port_reg[1] : s1_port_reg[0];
    assign ac_chan     = ac_master ? {1'b1, s1_port_reg[3:2]} : {1'b0, s1_port_reg[2:1]};
    assign low_page    = (s1_port_reg[15:8] == 8'd0);
    assign port_lo     = s1_port_reg[7:0];
    assign pg          = page_lookup(s1_port_reg);

    assign idx_cur  = (s1_mode_reg == MODE_ACK || s1_mode_reg == MODE_QUERY)
                      ? s1_chan_reg : ac_chan;
    assign idx_page = (s1_mode_reg == MODE_QUERY) ? s1_chan_reg : pg.chan;

    assign base_addr_rd = base_addr_reg[idx_cur];
    assign base_cnt_rd  = base_cnt_reg[idx_cur];
    assign cur_addr_rd  = cur_addr_reg[idx_cur];
    assign cur_cnt_rd   = cur_cnt_reg[idx_cur];
    assign page_rd      = page_reg[idx_page];
    assign chan_mode_rd = chan_mode_reg[s1_chan_reg];

    assign ac_val      = ac_is_count ? cur_cnt_rd : cur_addr_rd;
    assign ac_new_base = {s1_wdata_reg, ac_is_count ? base_cnt_rd[7:0] : base_addr_rd[7:0]};

    // channels 4-7 move 16-bit units; any nonzero byte count moves at least one
    assign units_raw = s1_chan_reg[2] ? {1'b0, s1_bytes_reg[15:1]} : s1_bytes_reg;
    assign units     = (units_raw == 16'd0 && s1_bytes_reg != 16'd0) ? 16'd1 : units_raw;
    assign addr_step = chan_mode_rd[MODE_BIT_DECREMENT] ? (cur_addr_rd - units)
                                                        : (cur_addr_rd + units);
    assign cnt_diff  = {1'b0, cur_cnt_rd} - {1'b0, units};
    assign ack_tc    = cnt_diff[16] || (cnt_diff[15:0] == 16'hFFFF);
    assign query_off = s1_chan_reg[2] ? {7'd0, cur_addr_rd, 1'b0} : {8'd0, cur_addr_rd};

    always_comb
    begin
        base_addr_next = base_addr_reg;
        base_cnt_next  = base_cnt_reg;
        cur_addr_next  = cur_addr_reg;
        cur_cnt_next   = cur_cnt_reg;
        page_next      = page_reg;
        chan_mode_next = chan_mode_reg;
        masked_next    = masked_reg;
        byte_ff_next   = byte_ff_reg;
        tc_status_next = tc_status_reg;

        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_rdata_next  = rsp_rdata_reg;
        rsp_tc_next     = rsp_tc_reg;
        rsp_linear_next = rsp_linear_reg;
        rsp_count_next  = rsp_count_reg;

        if (fire)
        begin
            rsp_valid_next  = 1'b1;
            rsp_rdata_next  = 8'd0;
            rsp_tc_next     = 1'b0;
            rsp_linear_next = 24'd0;
            rsp_count_next  = 16'd0;

            unique case (s1_mode_reg)
                MODE_READ:
                begin
                    if (ac_hit)
                    begin
                        rsp_rdata_next = byte_ff_reg[ac_master] ? ac_val[15:8] : ac_val[7:0];
                        byte_ff_next[ac_master] = !byte_ff_reg[ac_master];
                    end
                    else if (low_page && port_lo == PORT_STATUS_SLV)
                        rsp_rdata_next = {4'd0, tc_status_reg[3:0]};
                    else if (low_page && port_lo == PORT_STATUS_MST)
                        rsp_rdata_next = {4'd0, tc_status_reg[7:4]};
                    else if (pg.hit)
                        rsp_rdata_next = page_rd;
                    else
                        rsp_rdata_next = 8'hFF;
                end
                MODE_WRITE:
                begin
                    if (ac_hit)
                    begin
                        if (!byte_ff_reg[ac_master])
                        begin
                            if (ac_is_count)
                                base_cnt_next[idx_cur] = {base_cnt_rd[15:8], s1_wdata_reg};
                            else
                                base_addr_next[idx_cur] = {base_addr_rd[15:8], s1_wdata_reg};
                        end
                        else if (ac_is_count)
                        begin
                            base_cnt_next[idx_cur] = ac_new_base;
                            cur_cnt_next[idx_cur]  = ac_new_base;
                        end
                        else
                        begin
                            base_addr_next[idx_cur] = ac_new_base;
                            cur_addr_next[idx_cur]  = ac_new_base;
                        end
                        byte_ff_next[ac_master] = !byte_ff_reg[ac_master];
                    end
                    else if (low_page)
                    begin
                        unique case (port_lo)
                            PORT_MASK_SLV:
                                masked_next[{1'b0, s1_wdata_reg[1:0]}] = s1_wdata_reg[2];
                            PORT_MODE_SLV:
                                chan_mode_next[{1'b0, s1_wdata_reg[1:0]}] = s1_wdata_reg;
                            PORT_CLRFF_SLV:
                                byte_ff_next[0] = 1'b0;
                            PORT_MCLR_SLV:
                            begin
                                byte_ff_next[0]     = 1'b0;
                                tc_status_next[3:0] = 4'd0;
                                masked_next[3:0]    = 4'hF;
                            end
                            PORT_MASK_MST:
                                masked_next[{1'b1, s1_wdata_reg[1:0]}] = s1_wdata_reg[2];
                            PORT_MODE_MST:
                                chan_mode_next[{1'b1, s1_wdata_reg[1:0]}] = s1_wdata_reg;
                            PORT_CLRFF_MST:
                                byte_ff_next[1] = 1'b0;
                            PORT_MCLR_MST:
                            begin
                                byte_ff_next[1]     = 1'b0;
                                tc_status_next[7:4] = 4'd0;
                                masked_next[7:4]    = 4'hF;
                            end
                            default:
                            begin
                                if (pg.hit)
                                    page_next[idx_page] = s1_wdata_reg;
                            end
                        endcase
                    end
                end
                MODE_ACK:
                begin
                    rsp_tc_next = ack_tc;
                    if (ack_tc)
                    begin
                        tc_status_next[s1_chan_reg] = 1'b1;
                        if (chan_mode_rd[MODE_BIT_AUTOINIT])
                        begin
                            cur_addr_next[idx_cur] = base_addr_rd;
                            cur_cnt_next[idx_cur]  = base_cnt_rd;
                        end
                        else
                        begin
                            cur_addr_next[idx_cur] = addr_step;
                            cur_cnt_next[idx_cur]  = 16'hFFFF;
                            masked_next[s1_chan_reg] = 1'b1;
                        end
                    end
                    else
                    begin
                        cur_addr_next[idx_cur] = addr_step;
                        cur_cnt_next[idx_cur]  = cnt_diff[15:0];
                    end
                end
                MODE_QUERY:
                begin
                    rsp_linear_next = {page_rd, 16'd0} | query_off;
                    rsp_count_next  = cur_cnt_rd;
                end
                default:
                begin
                    rsp_valid_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            masked_reg    <= 8'hFF;
            byte_ff_reg   <= 2'd0;
            tc_status_reg <= 8'd0;
            for (int i = 0; i < 8; i++)
            begin
                base_addr_reg[i] <= 16'd0;
                base_cnt_reg[i]  <= 16'd0;
                cur_addr_reg[i]  <= 16'd0;
                cur_cnt_reg[i]   <= 16'd0;
                page_reg[i]      <= 8'd0;
                chan_mode_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            rsp_valid_reg  <= rsp_valid_next;
            masked_reg     <= masked_next;
            byte_ff_reg    <= byte_ff_next;
            tc_status_reg  <= tc_status_next;
            base_addr_reg  <= base_addr_next;
            base_cnt_reg   <= base_cnt_next;
            cur_addr_reg   <= cur_addr_next;
            cur_cnt_reg    <= cur_cnt_next;
            page_reg       <= page_next;
            chan_mode_reg  <= chan_mode_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_mode_reg  <= req.mode;
            s1_port_reg  <= req.bus_port;
            s1_wdata_reg <= req.write_data;
            s1_chan_reg  <= req.channel;
            s1_bytes_reg <= req.byte_count;
        end
        rsp_rdata_reg  <= rsp_rdata_next;
        rsp_tc_reg     <= rsp_tc_next;
        rsp_linear_reg <= rsp_linear_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.read_data      = rsp_rdata_reg;
    assign rsp.terminal_count = rsp_tc_reg;
    assign rsp.linear_address = rsp_linear_reg;
    assign rsp.current_count  = rsp_count_reg;

    // request side stalls only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && rsp_valid_reg && !rsp.ready))
        else $error("request stalled without a held result");

    // terminal count leaves the channel's status bit set
    a_tc_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_mode_reg == MODE_ACK && ack_tc) |=> tc_status_reg[$past(s1_chan_reg)])
        else $error("terminal count did not set status");

    // master clear on the slave masks channels 0-3
    a_mclr_slv: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && s1_mode_reg == MODE_WRITE && s1_port_reg == {8'd0, PORT_MCLR_SLV})
        |=> (masked_reg[3:0] == 4'hF && tc_status_reg[3:0] == 4'd0))
        else $error("slave master clear incomplete");

    // a processed word always lands in the result register
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid_reg)
        else $error("processed word lost");

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for isa_dma_channel_controller_core: drives port reads, writes, transfer acks and
// channel queries, and checks every result word against a shadow of the register file.
// Depends on idc_pkg, idc_req_if, idc_rsp_if and the core.

module testbench;
    import idc_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port;
        logic [7:0]  data;
        logic [2:0]  chan;
        logic [15:0] nbytes;
    } dma_word_t;

    typedef struct packed {
        logic [7:0]  rd;
        logic        tc;
        logic [23:0] lin;
        logic [15:0] cnt;
    } dma_result_t;

    localparam logic [15:0] PAGE_PORT [8] = '{16'h0087, 16'h0083, 16'h0081, 16'h0082,
                                              16'h008F, 16'h008B, 16'h0089, 16'h008A};
    localparam logic [7:0] CTRL_PORT [10] = '{PORT_STATUS_SLV, PORT_MASK_SLV, PORT_MODE_SLV,
                                              PORT_CLRFF_SLV, PORT_MCLR_SLV, PORT_STATUS_MST,
                                              PORT_MASK_MST, PORT_MODE_MST, PORT_CLRFF_MST,
                                              PORT_MCLR_MST};
    localparam int RANDOM_WORDS = 1200;

    // Shadow copy of both controllers; works out the result word for each accepted word.
    class dma_shadow_regs;
        logic [15:0] base_addr [8];
        logic [15:0] base_cnt [8];
        logic [15:0] cur_addr [8];
        logic [15:0] cur_cnt [8];
        logic [7:0]  page [8];
        logic [7:0]  chmode [8];
        bit          masked [8];
        bit          ff [2];
        logic [3:0]  tc_bits [2];
        dma_result_t owed_results [$];
        int          failures;

        function new();
            for (int i = 0; i < 8; i++)
            begin
                base_addr[i] = '0;
                base_cnt[i]  = '0;
                cur_addr[i]  = '0;
                cur_cnt[i]   = '0;
                page[i]      = '0;
                chmode[i]    = '0;
                masked[i]    = 1'b1;
            end
            ff[0] = 1'b0;
            ff[1] = 1'b0;
            tc_bits[0] = '0;
            tc_bits[1] = '0;
            failures = 0;
        endfunction

        // address/count port decode: channel or -1
        function int acc_channel(logic [15:0] port, output bit is_cnt, output bit ctl);
            is_cnt = 1'b0;
            ctl    = 1'b0;
            if (port <= 16'h0007)
            begin
                is_cnt = port[0];
                return int'(port[2:1]);
            end
            if (port >= 16'h00C0 && port <= 16'h00CE && !port[0])
            begin
                is_cnt = port[1];
                ctl    = 1'b1;
                return 4 + int'(port[3:2]);
            end
            return -1;
        endfunction

        function int page_of(logic [15:0] port);
            for (int i = 0; i < 8; i++)
                if (PAGE_PORT[i] == port)
                    return i;
            return -1;
        endfunction

        function dma_result_t apply_word(dma_word_t w);
            dma_result_t r;
            int          ch;
            int          pg;
            bit          is_cnt;
            bit          ctl;
            logic [15:0] v;
            logic [15:0] units;
            logic [16:0] a;
            r  = '0;
            ch = acc_channel(w.port, is_cnt, ctl);
            pg = page_of(w.port);
            case (w.kind)
                MODE_READ:
                begin
                    if (ch >= 0)
                    begin
                        v = is_cnt ? cur_cnt[ch] : cur_addr[ch];
                        r.rd = ff[ctl] ? v[15:8] : v[7:0];
                        ff[ctl] = !ff[ctl];
                    end
                    else if (w.port == {8'h00, PORT_STATUS_SLV})
                        r.rd = {4'h0, tc_bits[0]};
                    else if (w.port == {8'h00, PORT_STATUS_MST})
                        r.rd = {4'h0, tc_bits[1]};
                    else if (pg >= 0)
                        r.rd = page[pg];
                    else
                        r.rd = 8'hFF;
                end
                MODE_WRITE:
                begin
                    if (ch >= 0)
                    begin
                        // high byte loads the current register from base
                        if (!ff[ctl])
                        begin
                            if (is_cnt) base_cnt[ch][7:0] = w.data;
                            else        base_addr[ch][7:0] = w.data;
                        end
                        else if (is_cnt)
                        begin
                            base_cnt[ch][15:8] = w.data;
                            cur_cnt[ch] = base_cnt[ch];
                        end
                        else
                        begin
                            base_addr[ch][15:8] = w.data;
                            cur_addr[ch] = base_addr[ch];
                        end
                        ff[ctl] = !ff[ctl];
                    end
                    else if (w.port[15:8] == 8'h00)
                    begin
                        if (pg >= 0)
                            page[pg] = w.data;
                        case (w.port[7:0])
                            PORT_MASK_SLV:  masked[w.data[1:0]] = w.data[2];
                            PORT_MODE_SLV:  chmode[w.data[1:0]] = w.data;
                            PORT_CLRFF_SLV: ff[0] = 1'b0;
                            PORT_MCLR_SLV:
                            begin
                                ff[0] = 1'b0;
                                tc_bits[0] = '0;
                                for (int i = 0; i < 4; i++) masked[i] = 1'b1;
                            end
                            PORT_MASK_MST:  masked[4 + w.data[1:0]] = w.data[2];
                            PORT_MODE_MST:  chmode[4 + w.data[1:0]] = w.data;
                            PORT_CLRFF_MST: ff[1] = 1'b0;
                            PORT_MCLR_MST:
                            begin
                                ff[1] = 1'b0;
                                tc_bits[1] = '0;
                                for (int i = 4; i < 8; i++) masked[i] = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                MODE_ACK:
                begin
                    // word channels count in halves, but any bytes move at least one unit
                    units = w.chan[2] ? {1'b0, w.nbytes[15:1]} : w.nbytes;
                    if (units == 16'h0 && w.nbytes != 16'h0)
                        units = 16'h1;
                    if (chmode[w.chan][MODE_BIT_DECREMENT])
                        cur_addr[w.chan] = cur_addr[w.chan] - units;
                    else
                        cur_addr[w.chan] = cur_addr[w.chan] + units;
                    if (cur_cnt[w.chan] < units)
                    begin
                        cur_cnt[w.chan] = 16'hFFFF;
                        r.tc = 1'b1;
                    end
                    else
                    begin
                        cur_cnt[w.chan] = cur_cnt[w.chan] - units;
                        r.tc = (cur_cnt[w.chan] == 16'hFFFF);
                    end
                    if (r.tc)
                    begin
                        tc_bits[w.chan[2]][w.chan[1:0]] = 1'b1;
                        if (chmode[w.chan][MODE_BIT_AUTOINIT])
                        begin
                            cur_addr[w.chan] = base_addr[w.chan];
                            cur_cnt[w.chan]  = base_cnt[w.chan];
                        end
                        else
                            masked[w.chan] = 1'b1;
                    end
                end
                default:
                begin
                    a = w.chan[2] ? {cur_addr[w.chan], 1'b0} : {1'b0, cur_addr[w.chan]};
                    r.lin = {page[w.chan], 16'h0000} | {7'h00, a};
                    r.cnt = cur_cnt[w.chan];
                end
            endcase
            return r;
        endfunction

        function void note_word(dma_word_t w);
            owed_results.push_back(apply_word(w));
        endfunction

        function void compare_field(string name, int unsigned exp, int unsigned got);
            if (exp != got)
            begin
                failures++;
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, got);
            end
        endfunction

        function void check_word(dma_result_t got);
            dma_result_t exp;
            if (owed_results.size() == 0)
            begin
                failures++;
                $error("result word with nothing outstanding");
                return;
            end
            exp = owed_results.pop_front();
            compare_field("read_data", exp.rd, got.rd);
            compare_field("terminal_count", exp.tc, got.tc);
            compare_field("linear_address", exp.lin, got.lin);
            compare_field("current_count", exp.cnt, got.cnt);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   stall_left;

    dma_shadow_regs sb = new();

    idc_req_if req_ch ();
    idc_rsp_if rsp_ch ();

    isa_dma_channel_controller_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result side: check accepted words, stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_word({rsp_ch.read_data, rsp_ch.terminal_count,
                               rsp_ch.linear_address, rsp_ch.current_count});
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    function automatic dma_word_t word(logic [1:0] kind, logic [15:0] port, logic [7:0] data,
                                       logic [2:0] chan, logic [15:0] nbytes);
        dma_word_t w;
        w.kind   = kind;
        w.port   = port;
        w.data   = data;
        w.chan   = chan;
        w.nbytes = nbytes;
        return w;
    endfunction

    function automatic logic [15:0] mapped_port();
        int j;
        j = $urandom_range(0, 9);
        if (j < 3)
            return 16'($urandom_range(0, 7));
        if (j < 6)
            return 16'h00C0 + 16'(2 * $urandom_range(0, 7));
        if (j < 8)
            return PAGE_PORT[3'($urandom_range(0, 7))];
        return {8'h00, CTRL_PORT[4'($urandom_range(0, 9))]};
    endfunction

    // mostly well-formed programming and transfer traffic, some raw noise
    function automatic dma_word_t random_word();
        int          k;
        logic [7:0]  d;
        logic [15:0] n;
        k = $urandom_range(0, 99);
        d = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        n = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if (k < 30)
            return word(MODE_ACK, 16'($urandom), 8'($urandom), 3'($urandom), n);
        if (k < 45)
            return word(MODE_QUERY, 16'($urandom), 8'($urandom), 3'($urandom), 16'($urandom));
        if (k < 70)
            return word(MODE_WRITE, mapped_port(), d, 3'($urandom), 16'($urandom));
        if (k < 88)
            return word(MODE_READ, mapped_port(), 8'($urandom), 3'($urandom), 16'($urandom));
        return word(2'($urandom), 16'($urandom), 8'($urandom), 3'($urandom), 16'($urandom));
    endfunction

    task automatic send_word(input dma_word_t w);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 6);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= w.kind;
        req_ch.bus_port   <= w.port;
        req_ch.write_data <= w.data;
        req_ch.channel    <= w.chan;
        req_ch.byte_count <= w.nbytes;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_word(w);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        calm              = 1'b0;
        stall_left        = 0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = MODE_READ;
        req_ch.bus_port   = '0;
        req_ch.write_data = '0;
        req_ch.channel    = '0;
        req_ch.byte_count = '0;
        rsp_ch.ready      = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(word(MODE_READ, 16'hFFFF, 8'h00, 3'd0, 16'h0000));    // unmapped
        send_word(word(MODE_WRITE, {8'h00, PORT_STATUS_SLV}, 8'hFF, 3'd7, 16'hFFFF));
        send_word(word(MODE_READ, {8'h00, PORT_MASK_SLV}, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, {8'h00, PORT_CLRFF_SLV}, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, 16'h0000, 8'hFF, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, 16'h0000, 8'hFF, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, 16'h0001, 8'h02, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, 16'h0001, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, PAGE_PORT[0], 8'hFF, 3'd0, 16'h0000));
        // channel 0: decrement with auto-init
        send_word(word(MODE_WRITE, {8'h00, PORT_MODE_SLV}, 8'h30, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, {8'h00, PORT_MASK_SLV}, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_ACK, 16'h0000, 8'h00, 3'd0, 16'hFFFF));       // underflow
        send_word(word(MODE_QUERY, 16'h0000, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, {8'h00, PORT_CLRFF_MST}, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, 16'h00CC, 8'hFF, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, 16'h00CC, 8'hFF, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, PAGE_PORT[7], 8'hFF, 3'd0, 16'h0000));
        send_word(word(MODE_QUERY, 16'h0000, 8'h00, 3'd7, 16'h0000));    // 24-bit wrap
        send_word(word(MODE_ACK, 16'h0000, 8'h00, 3'd7, 16'h0001));      // one byte, one unit
        send_word(word(MODE_ACK, 16'h0000, 8'h00, 3'd7, 16'h0000));      // zero units on FFFF
        send_word(word(MODE_READ, {8'h00, PORT_STATUS_MST}, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_READ, {8'h00, PORT_STATUS_MST}, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_WRITE, {8'h00, PORT_MCLR_MST}, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_READ, {8'h00, PORT_STATUS_MST}, 8'h00, 3'd0, 16'h0000));
        send_word(word(MODE_READ, 16'h0000, 8'h00, 3'd0, 16'h0000));

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            calm = (i >= RANDOM_WORDS - 150) || ((i / 200) % 3 == 2);
            send_word(random_word());
        end
        req_ch.valid <= 1'b0;

        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> isa_dma_channel_controller_core.f
src/idc_pkg.sv
src/idc_req_if.sv
src/idc_rsp_if.sv
src/isa_dma_channel_controller_core.sv
dv/testbench.sv
